// ===== hw/rtl/three_wheel_holonomic_kinematics_assert.svh =====
// Assertion macros for the three-wheel kinematics block.
`ifndef THREE_WHEEL_HOLONOMIC_KINEMATICS_ASSERT_SVH
`define THREE_WHEEL_HOLONOMIC_KINEMATICS_ASSERT_SVH
`ifndef SYNTHESIS
`define TWK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TWK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TWK_ASSERT(label, clk, rst_n, prop, msg)
`define TWK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/twk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package twk_pkg;
  localparam int unsigned Wheels = 3;
  localparam int unsigned CordicSteps = 16;
  localparam logic [31:0] CordicGain = 32'd652032874;
  localparam logic [16:0] HalfPiQ16 = 17'd102944;
  localparam logic [10:0] Deg2RadQ16 = 11'd1144;
  localparam logic [15:0] QuarterTurn = 16'd16384;
  localparam logic [1:0] CfgEnable = 2'd0;
  localparam logic [1:0] CfgCounts = 2'd1;
  localparam logic [1:0] CfgRate = 2'd2;
  localparam logic ActUpdate = 1'b0;
  localparam logic ActLoad = 1'b1;

  function automatic logic [29:0] atan_f(input logic [3:0] i);
    logic [29:0] r;
    unique case (i)
      4'd0: r = 30'd536870912;
      4'd1: r = 30'd316933406;
      4'd2: r = 30'd167458907;
      4'd3: r = 30'd85004756;
      4'd4: r = 30'd42667331;
      4'd5: r = 30'd21354465;
      4'd6: r = 30'd10680862;
      4'd7: r = 30'd5340245;
      4'd8: r = 30'd2670163;
      4'd9: r = 30'd1335087;
      4'd10: r = 30'd667544;
      4'd11: r = 30'd333772;
      4'd12: r = 30'd166886;
      4'd13: r = 30'd83443;
      4'd14: r = 30'd41721;
      default: r = 30'd20861;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/twk_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module twk_divider import twk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [48:0] num_i,
  input  wire logic [27:0] den_i,
  output logic             done_o,
  output logic [48:0]      quo_o
);
  logic [48:0] quo_q, quo_d;
  logic [28:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [28:0] trial;
  logic [29:0] diff;

  always_comb begin
    trial = {rem_q[27:0], quo_q[48]};
    diff = {1'b0, trial} - {2'b0, den_i};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (diff[29]) begin
        rem_d = trial;
        quo_d = {quo_q[47:0], 1'b0};
      end else begin
        rem_d = diff[28:0];
        quo_d = {quo_q[47:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o = quo_d;
endmodule
`default_nettype wire

// ===== hw/rtl/three_wheel_holonomic_kinematics.sv =====
// Inverse kinematics for a three-wheel omni base. A load (action 1) stores
// one wheel's geometry. An update (action 0), when enabled,
// yields three consign results, wheel 0 to 2, each valid for exactly one
// cycle on valid_o with last_o on wheel 2; the receiver cannot stall, so
// take each result when valid_o is high. busy is high from the cycle after
// the update transfer through the third result. Each wheel takes a setup
// step, 16 CORDIC iterations, three multiply steps, a 49-step
// restoring divider and a result step. Configuration writes take effect
// at once.
`timescale 1ns / 1ps
`default_nettype none
`include "three_wheel_holonomic_kinematics_assert.svh"
module three_wheel_holonomic_kinematics import twk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        action_i,
  input  wire logic [1:0]  wheel_i,
  input  wire logic [15:0] heading_i,
  input  wire logic signed [15:0] travel_speed_i,
  input  wire logic [15:0] travel_direction_i,
  input  wire logic signed [15:0] spin_rate_i,
  input  wire logic [15:0] mount_angle_i,
  input  wire logic [9:0]  radius_mm_i,
  input  wire logic [11:0] arm_mm_i,
  output logic             valid_o,
  output logic [1:0]       wheel_index_o,
  output logic signed [31:0] consign_o,
  output logic             last_o
);
  typedef enum logic [7:0] {
    StIdle = 8'b00000001,
    StPrep = 8'b00000010,
    StCord = 8'b00000100,
    StSum  = 8'b00001000,
    StProd = 8'b00010000,
    StMul  = 8'b00100000,
    StDiv  = 8'b01000000,
    StOut  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic        enable_q;
  logic [15:0] cpt_q;
  logic [13:0] rate_q;
  logic [15:0] mount_q [Wheels];
  logic [9:0]  radius_q [Wheels];
  logic [11:0] arm_q [Wheels];
  logic [15:0] heading_q, dir_q;
  logic signed [15:0] speed_q, spin_q;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  step_q, step_d;
  logic        flip_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic signed [40:0] s_q;
  logic        neg_q;
  logic [56:0] p_q;
  logic [48:0] acc_q;
  logic [27:0] den_q;
  logic [48:0] quo;
  logic        div_start, div_done;

  logic [15:0] ang, ang2;
  logic        flip;
  logic signed [33:0] xs, ys;
  logic signed [34:0] xr;
  logic signed [19:0] craw;
  logic signed [16:0] cos_v;
  logic signed [40:0] sterm, aterm;
  logic [40:0] mag;
  logic [56:0] p;
  logic [48:0] qmul;
  logic [9:0]  rad;
  logic [13:0] rte;
  logic [23:0] rr;
  logic signed [31:0] val;

  always_comb begin
    ang = heading_q - dir_q + mount_q[idx_q] - QuarterTurn;
    flip = (ang >= 16'd16384) && (ang < 16'd49152);
    ang2 = flip ? ang - 16'd32768 : ang;
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    xr = {x_q[33], x_q} + 35'sd16384;
    craw = xr[34:15];
    if (flip_q) craw = -craw;
    if (craw > 20'sd32767) cos_v = 17'sd32767;
    else if (craw < -20'sd32768) cos_v = -17'sd32768;
    else cos_v = craw[16:0];
    sterm = 41'(speed_q) * 41'(cos_v) * 41'sd2;
    aterm = 41'(spin_q) * 41'($signed({1'b0, arm_q[idx_q]}))
            * 41'($signed({1'b0, Deg2RadQ16}));
    mag = s_q[40] ? 41'(-s_q) : 41'(s_q);
    p = 57'(mag) * 57'(cpt_q);
    qmul = 49'(p_q[56:32]) * 49'(HalfPiQ16)
         + 49'((64'(p_q[31:0]) * 64'(HalfPiQ16)) >> 32);
    rad = (radius_q[idx_q] == '0) ? 10'd1 : radius_q[idx_q];
    rte = (rate_q == '0) ? 14'd1 : rate_q;
    rr = 24'(rad) * 24'(rte);
    if (neg_q) val = (acc_q > 49'h80000000) ? 32'sh80000000 : 32'(-acc_q);
    else val = (acc_q > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(acc_q);
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    step_d = step_q;
    div_start = 1'b0;
    unique case (state_q)
      StIdle: if (start && action_i == ActUpdate && enable_q) begin
        state_d = StPrep;
        idx_d = '0;
      end
      StPrep: begin
        state_d = StCord;
        step_d = '0;
      end
      StCord: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'(CordicSteps - 1)) state_d = StSum;
      end
      StSum: state_d = StProd;
      StProd: state_d = StMul;
      StMul: begin
        state_d = StDiv;
        div_start = 1'b1;
      end
      StDiv: if (div_done) state_d = StOut;
      StOut: begin
        idx_d = idx_q + 2'd1;
        state_d = (idx_q == 2'(Wheels - 1)) ? StIdle : StPrep;
      end
      default: state_d = StIdle;
    endcase
  end

  twk_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (qmul),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      enable_q <= 1'b0;
      cpt_q <= 16'd1;
      rate_q <= 14'd1;
      idx_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      step_q <= step_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgEnable: enable_q <= cfg_data_i[0];
          CfgCounts: cpt_q <= cfg_data_i;
          CfgRate: rate_q <= cfg_data_i[13:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      heading_q <= heading_i;
      dir_q <= travel_direction_i;
      speed_q <= travel_speed_i;
      spin_q <= spin_rate_i;
      if (action_i == ActLoad && wheel_i < 2'(Wheels)) begin
        mount_q[wheel_i] <= mount_angle_i;
        radius_q[wheel_i] <= radius_mm_i;
        arm_q[wheel_i] <= arm_mm_i;
      end
    end
    unique case (state_q)
      StPrep: begin
        flip_q <= flip;
        x_q <= 34'(CordicGain);
        y_q <= '0;
        z_q <= 33'($signed(ang2)) <<< 16;
      end
      StCord: begin
        if (!z_q[32]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - 33'(atan_f(step_q));
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + 33'(atan_f(step_q));
        end
      end
      StSum: s_q <= sterm - aterm;
      StProd: begin
        neg_q <= s_q[40];
        p_q <= p;
      end
      StMul: begin
        acc_q <= qmul;
        den_q <= 28'(rr) * 28'd10;
      end
      StDiv: if (div_done) acc_q <= quo;
      default: ;
    endcase
  end

  assign busy = (state_q != StIdle);
  assign valid_o = (state_q == StOut);
  assign wheel_index_o = idx_q;
  assign consign_o = val;
  assign last_o = valid_o && (idx_q == 2'(Wheels - 1));

  `TWK_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `TWK_ASSERT_IMPL(a_last, clk_i, rst_ni, last_o, valid_o && idx_q == 2'd2, "bad last")
  `TWK_ASSERT_IMPL(a_idx, clk_i, rst_ni, valid_o, idx_q != 2'd3, "bad wheel index")
  `TWK_ASSERT_IMPL(a_done, clk_i, rst_ni, valid_o && last_o, ##1 !busy, "busy after last")
endmodule
`default_nettype wire
